/* design/bcdaad_pkg.sv */
package bcdaad_pkg;

    localparam int NIB_W      = 4;
    localparam int MAX_DIGITS = 16;
    localparam int WORD_W     = NIB_W * MAX_DIGITS;

    localparam logic [4:0] DIG_MAX = 5'd9;
    localparam logic [4:0] RADIX   = 5'd10;

    typedef struct packed {
        logic             bad;
        logic             gt;
        logic             lt;
        logic             sum_g;
        logic             sum_p;
        logic [4:0]       sum_raw;
        logic [NIB_W-1:0] a;
        logic [NIB_W-1:0] b;
    } lane_info_t;

endpackage

/* design/bcdaad_lane.sv */
module bcdaad_lane
    import bcdaad_pkg::*;
(
    input  logic [NIB_W-1:0] a,
    input  logic [NIB_W-1:0] b,
    output lane_info_t       info
);

    logic [4:0] sum_raw;

    assign sum_raw = {1'b0, a} + {1'b0, b};

    always_comb
    begin
        info.bad     = ({1'b0, a} > DIG_MAX) || ({1'b0, b} > DIG_MAX);
        info.gt      = a > b;
        info.lt      = a < b;
        info.sum_raw = sum_raw;
        info.sum_g   = sum_raw > DIG_MAX;
        info.sum_p   = sum_raw == DIG_MAX;
        info.a       = a;
        info.b       = b;
    end

endmodule

/* design/bcdaad_merge.sv */
module bcdaad_merge #(
    parameter int DIGITS = 16
) (
    input  logic [DIGITS-1:0] bad,
    input  logic [DIGITS-1:0] gt,
    input  logic [DIGITS-1:0] lt,
    input  logic [DIGITS-1:0] sum_g,
    input  logic [DIGITS-1:0] sum_p,
    output logic [DIGITS-1:0] carry_in,
    output logic              carry_out,
    output logic [DIGITS-1:0] borrow_ab,
    output logic [DIGITS-1:0] borrow_ba,
    output logic              negative,
    output logic              any_bad
);

    // carry/borrow lookahead as one binary add: (gen|prop) + gen
    logic [DIGITS-1:0] eq;
    logic [DIGITS:0]   cx, cy, cs, cc;
    logic [DIGITS:0]   ax, ay, as_sum, ac;
    logic [DIGITS:0]   bx, by, bs_sum, bc;

    assign eq = ~(gt | lt);

    assign cx = {1'b0, sum_g | sum_p};
    assign cy = {1'b0, sum_g};
    assign cs = cx + cy;
    assign cc = cs ^ cx ^ cy;

    assign ax     = {1'b0, lt | eq};
    assign ay     = {1'b0, lt};
    assign as_sum = ax + ay;
    assign ac     = as_sum ^ ax ^ ay;

    assign bx     = {1'b0, gt | eq};
    assign by     = {1'b0, gt};
    assign bs_sum = bx + by;
    assign bc     = bs_sum ^ bx ^ by;

    assign carry_in  = cc[DIGITS-1:0];
    assign carry_out = cc[DIGITS];
    assign borrow_ab = ac[DIGITS-1:0];
    assign borrow_ba = bc[DIGITS-1:0];

    // highest differing digit decides; lt and gt never share a bit
    assign negative = lt > gt;
    assign any_bad  = |bad;

endmodule

/* design/bcdaad_fix.sv */
module bcdaad_fix
    import bcdaad_pkg::*;
(
    input  logic [NIB_W-1:0] a,
    input  logic [NIB_W-1:0] b,
    input  logic [4:0]       sum_raw,
    input  logic             cin,
    input  logic             bin,
    input  logic             negative,
    output logic [NIB_W-1:0] sum_digit,
    output logic [NIB_W-1:0] diff_digit
);

    logic [4:0] t;
    logic [4:0] x;
    logic [4:0] y;
    logic [4:0] t_adj;
    logic [4:0] d_wrap;
    logic [4:0] d_plain;

    assign t       = sum_raw + {4'b0, cin};
    assign t_adj   = t - RADIX;
    assign x       = {1'b0, negative ? b : a};
    assign y       = {1'b0, negative ? a : b} + {4'b0, bin};
    assign d_wrap  = x + RADIX - y;
    assign d_plain = x - y;

    assign sum_digit  = (t > DIG_MAX) ? t_adj[NIB_W-1:0] : t[NIB_W-1:0];
    assign diff_digit = (x < y) ? d_wrap[NIB_W-1:0] : d_plain[NIB_W-1:0];

endmodule

/* design/bcd_add_and_abs_difference.sv */
// Lane results are registered into s1 at the accept edge, the merge results into s2,
// and the fixup results into the output registers.
// Throughput: one request per cycle while out_stall is low; the three stages hold up to three requests.
// Carry, borrow and order across digits are resolved in the merge stage by
// ND+1 bit adds; per-digit work runs in ND parallel lanes (DIGITS clamped to 1..16).
// Reset (rst_n low, asynchronous) empties the pipeline; payload is not cleared.
module bcd_add_and_abs_difference
    import bcdaad_pkg::*;
#(
    parameter int DIGITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [WORD_W-1:0] first_digits,
    input  logic [WORD_W-1:0] second_digits,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] sum_digits,
    output logic              sum_carry,
    output logic [WORD_W-1:0] difference_digits,
    output logic              difference_negative,
    output logic              bad_digit
);

    localparam int ND = (DIGITS < 1) ? 1 : ((DIGITS > MAX_DIGITS) ? MAX_DIGITS : DIGITS);

    lane_info_t lane_info [ND];
    lane_info_t s1_info_reg [ND];
    lane_info_t s2_info_reg [ND];

    logic [ND-1:0] s1_bad, s1_gt, s1_lt, s1_g, s1_p;
    logic [ND-1:0] m_carry_in, m_borrow_ab, m_borrow_ba;
    logic          m_carry_out, m_negative, m_any_bad;

    logic [ND-1:0] s2_carry_in_reg, s2_borrow_in_reg;
    logic          s2_carry_out_reg, s2_negative_reg, s2_bad_reg;

    logic [NIB_W-1:0] fix_sum [ND];
    logic [NIB_W-1:0] fix_diff [ND];

    logic v1_reg, v1_next, v2_reg, v2_next, out_valid_reg, out_valid_next;
    logic out_free, s2_free, s1_free;

    logic [WORD_W-1:0] sum_reg, sum_next, diff_reg, diff_next;
    logic              carry_reg, carry_next, neg_reg, neg_next, bad_reg, bad_next;

    genvar gi;
    generate
        for (gi = 0; gi < ND; gi++)
        begin : g_lane
            bcdaad_lane u_lane (
                .a    (first_digits[NIB_W*gi +: NIB_W]),
                .b    (second_digits[NIB_W*gi +: NIB_W]),
                .info (lane_info[gi])
            );

            assign s1_bad[gi] = s1_info_reg[gi].bad;
            assign s1_gt[gi]  = s1_info_reg[gi].gt;
            assign s1_lt[gi]  = s1_info_reg[gi].lt;
            assign s1_g[gi]   = s1_info_reg[gi].sum_g;
            assign s1_p[gi]   = s1_info_reg[gi].sum_p;

            bcdaad_fix u_fix (
                .a          (s2_info_reg[gi].a),
                .b          (s2_info_reg[gi].b),
                .sum_raw    (s2_info_reg[gi].sum_raw),
                .cin        (s2_carry_in_reg[gi]),
                .bin        (s2_borrow_in_reg[gi]),
                .negative   (s2_negative_reg),
                .sum_digit  (fix_sum[gi]),
                .diff_digit (fix_diff[gi])
            );
        end
    endgenerate

    bcdaad_merge #(
        .DIGITS (ND)
    ) u_merge (
        .bad       (s1_bad),
        .gt        (s1_gt),
        .lt        (s1_lt),
        .sum_g     (s1_g),
        .sum_p     (s1_p),
        .carry_in  (m_carry_in),
        .carry_out (m_carry_out),
        .borrow_ab (m_borrow_ab),
        .borrow_ba (m_borrow_ba),
        .negative  (m_negative),
        .any_bad   (m_any_bad)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !v2_reg || out_free;
    assign s1_free  = !v1_reg || s2_free;
    assign in_stall = !s1_free;

    assign v1_next        = s1_free ? in_valid : v1_reg;
    assign v2_next        = s2_free ? v1_reg : v2_reg;
    assign out_valid_next = out_free ? v2_reg : out_valid_reg;

    always_comb
    begin
        sum_next   = '0;
        diff_next  = '0;
        bad_next   = s2_bad_reg;
        carry_next = s2_carry_out_reg && !s2_bad_reg;
        neg_next   = s2_negative_reg && !s2_bad_reg;
        for (int i = 0; i < ND; i++)
        begin
            if (!s2_bad_reg)
            begin
                sum_next[NIB_W*i +: NIB_W]  = fix_sum[i];
                diff_next[NIB_W*i +: NIB_W] = fix_diff[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            for (int i = 0; i < ND; i++)
            begin
                s1_info_reg[i] <= lane_info[i];
            end
        end
        if (s2_free)
        begin
            for (int i = 0; i < ND; i++)
            begin
                s2_info_reg[i] <= s1_info_reg[i];
            end
            s2_carry_in_reg  <= m_carry_in;
            s2_carry_out_reg <= m_carry_out;
            s2_borrow_in_reg <= m_negative ? m_borrow_ba : m_borrow_ab;
            s2_negative_reg  <= m_negative;
            s2_bad_reg       <= m_any_bad;
        end
        if (out_free)
        begin
            sum_reg   <= sum_next;
            diff_reg  <= diff_next;
            carry_reg <= carry_next;
            neg_reg   <= neg_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_valid           = out_valid_reg;
    assign sum_digits          = sum_reg;
    assign sum_carry           = carry_reg;
    assign difference_digits   = diff_reg;
    assign difference_negative = neg_reg;
    assign bad_digit           = bad_reg;

`ifndef SYNTHESIS
    a_bad_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_digit |-> sum_digits == '0 && difference_digits == '0
            && !sum_carry && !difference_negative)
        else $error("bad digit result not cleared");

    a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_digit && difference_negative |-> difference_digits != '0)
        else $error("negative difference with zero magnitude");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && out_valid_reg)
        else $error("input stalled with room in pipeline");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted request not captured");
`endif

endmodule
